[hw/rtl/bqps_pkg.sv]
// Shared types and constants for the burst quota path scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bqps_pkg;

  localparam int unsigned MASK_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned QUOTA_W = 24;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned SUB_W   = 3;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic OP_NEW      = 1'b0;
  localparam logic OP_REINJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_SEGMENTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMITED = 1'd1;

  localparam logic [BURST_W-1:0] BURST_RESET = 16'd10000;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic div_done;
  } dp_status_t;

endpackage

[hw/rtl/bqps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the per-subpath quota store.
`timescale 1ns / 1ps

module bqps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bqps_div.sv]
// Restoring divider, one quotient bit per cycle, for the quota increment.
// Depends on bqps_pkg for the operand width.
`timescale 1ns / 1ps

module bqps_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bqps_pkg::LEN_W-1:0] num_i,
  input  logic [bqps_pkg::LEN_W-1:0] den_i,
  output logic [bqps_pkg::LEN_W-1:0] quo_o,
  output logic [bqps_pkg::LEN_W-1:0] rem_o,
  output logic                       done_o
);

  localparam int unsigned W  = bqps_pkg::LEN_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = !busy_q;

endmodule

[hw/rtl/bqps_datapath.sv]
// Datapath of the scheduler: item capture, quota store scan, decision,
// quota update and result register. Depends on bqps_pkg, bqps_ram, bqps_div.
`timescale 1ns / 1ps

module bqps_datapath #(
  parameter int unsigned NUM_PATHS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bqps_pkg::ctrl_cmd_t               cmd_i,
  output bqps_pkg::dp_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [bqps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bqps_pkg::BURST_W-1:0]      cfg_data_i,
  input  logic                              in_op_i,
  input  logic [bqps_pkg::LEN_W-1:0]        in_seg_len_i,
  input  logic [bqps_pkg::LEN_W-1:0]        in_mss_now_i,
  input  logic [bqps_pkg::MASK_W-1:0]       in_avail_window_i,
  input  logic [bqps_pkg::MASK_W-1:0]       in_avail_plain_i,
  input  logic [bqps_pkg::MASK_W-1:0]       in_sent_mask_i,
  input  logic                              in_is_data_fin_i,
  input  logic                              in_rcv_shut_i,
  input  logic [bqps_pkg::SUB_W-1:0]        in_fin_path_i,
  output logic                              out_found_o,
  output logic [bqps_pkg::SUB_W-1:0]        out_subpath_o,
  output logic [bqps_pkg::LIMIT_W-1:0]      out_send_limit_o,
  output logic                              out_clear_sent_o
);

  localparam int unsigned AW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int unsigned CW = $clog2(NUM_PATHS + 1);
  localparam int unsigned LW = bqps_pkg::LEN_W;
  localparam int unsigned QW = bqps_pkg::QUOTA_W;
  localparam int unsigned BW = bqps_pkg::BURST_W;
  localparam int unsigned MW = bqps_pkg::MASK_W;

  // Configuration registers.
  logic [BW-1:0] burst_q;
  logic          window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q  <= bqps_pkg::BURST_RESET;
      window_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bqps_pkg::CFG_BURST_SEGMENTS: burst_q  <= cfg_data_i;
        bqps_pkg::CFG_WINDOW_LIMITED: window_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic                        op_q;
  logic [LW-1:0]               len_q;
  logic [LW-1:0]               mss_q;
  logic [MW-1:0]               aw_q;
  logic [MW-1:0]               ap_q;
  logic [MW-1:0]               sent_q;
  logic                        dfin_q;
  logic                        shut_q;
  logic [bqps_pkg::SUB_W-1:0]  fin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      len_q  <= in_seg_len_i;
      mss_q  <= in_mss_now_i;
      aw_q   <= in_avail_window_i;
      ap_q   <= in_avail_plain_i;
      sent_q <= in_sent_mask_i;
      dfin_q <= in_is_data_fin_i;
      shut_q <= in_rcv_shut_i;
      fin_q  <= in_fin_path_i;
    end
  end

  logic [NUM_PATHS-1:0] aw_vec;
  logic [NUM_PATHS-1:0] ap_vec;
  logic [NUM_PATHS-1:0] sent_vec;
  logic [NUM_PATHS-1:0] elig_vec;

  for (genvar g = 0; g < NUM_PATHS; g++) begin : g_mask
    if (g < MW) begin : g_in
      assign aw_vec[g]   = aw_q[g];
      assign ap_vec[g]   = ap_q[g];
      assign sent_vec[g] = sent_q[g];
    end else begin : g_out
      assign aw_vec[g]   = 1'b0;
      assign ap_vec[g]   = 1'b0;
      assign sent_vec[g] = 1'b0;
    end
  end

  assign elig_vec = window_q ? aw_vec : ap_vec;

  // Divider for ceil(seg_len / mss), started as the item is taken.
  logic [LW-1:0] div_quo;
  logic [LW-1:0] div_rem;
  logic          div_done;
  logic [LW-1:0] div_den;
  logic [LW-1:0] div_den_q;

  assign div_den = (in_mss_now_i == '0) ? LW'(1) : in_mss_now_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_den_q <= div_den;
    end
  end

  bqps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .num_i   (in_seg_len_i),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // Quota store with per-entry valid bits; an entry that is not valid is zero.
  logic [NUM_PATHS-1:0] valid_q, valid_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        ev_idx_q;
  logic                 ev_vld_q;
  logic [QW-1:0]        ram_rdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [QW-1:0]        ram_wdata;
  logic [QW-1:0]        ev_quota;

  bqps_ram #(
    .WIDTH (QW),
    .DEPTH (NUM_PATHS)
  ) u_quota_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ev_quota = valid_q[ev_idx_q] ? ram_rdata : '0;
  assign cnt_d    = (cnt_q < CW'(NUM_PATHS)) ? cnt_q + 1'b1 : cnt_q;

  // Scan results.
  logic          part_any_q;
  logic [AW-1:0] part_idx_q;
  logic [BW-1:0] part_q_q;
  logic          zero_any_q;
  logic [AW-1:0] zero_idx_q;
  logic          seen_any_q;
  logic          notfull_any_q;
  logic [AW-1:0] last_elig_q;
  logic          best_any_q;
  logic [AW-1:0] best_idx_q;
  logic          backup_any_q;
  logic [AW-1:0] backup_idx_q;

  logic ev_elig;
  logic ev_below;

  assign ev_elig  = elig_vec[ev_idx_q];
  assign ev_below = ev_quota < {{(QW - BW){1'b0}}, burst_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ev_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q    <= '0;
      ev_vld_q <= 1'b0;
    end else if (cmd_i.step) begin
      cnt_q    <= cnt_d;
      ev_vld_q <= cnt_q < CW'(NUM_PATHS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      part_any_q    <= 1'b0;
      zero_any_q    <= 1'b0;
      seen_any_q    <= 1'b0;
      notfull_any_q <= 1'b0;
      best_any_q    <= 1'b0;
      backup_any_q  <= 1'b0;
    end else if (cmd_i.step) begin
      ev_idx_q <= cnt_q[AW-1:0];
      if (ev_vld_q) begin
        if (ev_elig) begin
          seen_any_q  <= 1'b1;
          last_elig_q <= ev_idx_q;
          if (ev_below) begin
            notfull_any_q <= 1'b1;
          end
          if (!part_any_q && ev_quota != '0 && ev_below) begin
            part_any_q <= 1'b1;
            part_idx_q <= ev_idx_q;
            part_q_q   <= ev_quota[BW-1:0];
          end
          if (ev_quota == '0) begin
            zero_any_q <= 1'b1;
            zero_idx_q <= ev_idx_q;
          end
        end
        if (aw_vec[ev_idx_q]) begin
          if (sent_vec[ev_idx_q]) begin
            backup_any_q <= 1'b1;
            backup_idx_q <= ev_idx_q;
          end else begin
            best_any_q <= 1'b1;
            best_idx_q <= ev_idx_q;
          end
        end
      end
    end
  end

  // Decision.
  logic          has;
  logic [AW-1:0] ch;
  logic [BW-1:0] split;
  logic [QW-1:0] qbase;
  logic          clr_all;
  logic          clr_out;
  logic          hit;
  logic          fin_ok;
  logic [LW-1:0] inc;
  logic [QW:0]   sum;
  logic [QW-1:0] new_quota;
  logic [bqps_pkg::LIMIT_W-1:0] prod;

  assign fin_ok = {29'b0, fin_q} < 32'(NUM_PATHS);

  always_comb begin
    has     = 1'b0;
    ch      = '0;
    split   = burst_q;
    qbase   = '0;
    clr_all = 1'b0;
    clr_out = 1'b0;
    if (op_q == bqps_pkg::OP_REINJECT) begin
      if (shut_q && dfin_q && fin_ok && aw_q[fin_q]) begin
        has = 1'b1;
        ch  = AW'(fin_q);
      end else if (best_any_q) begin
        has = 1'b1;
        ch  = best_idx_q;
      end else if (backup_any_q) begin
        has     = 1'b1;
        ch      = backup_idx_q;
        clr_out = 1'b1;
      end
    end else begin
      if (part_any_q) begin
        has   = 1'b1;
        ch    = part_idx_q;
        split = burst_q - part_q_q;
        qbase = {{(QW - BW){1'b0}}, part_q_q};
      end else if (seen_any_q && !notfull_any_q) begin
        has     = 1'b1;
        ch      = last_elig_q;
        clr_all = 1'b1;
      end else if (zero_any_q) begin
        has = 1'b1;
        ch  = zero_idx_q;
      end
    end
  end

  assign hit  = has && (op_q == bqps_pkg::OP_REINJECT || aw_vec[ch]);
  assign inc  = (len_q > div_den_q) ? div_quo + LW'(div_rem != '0) : LW'(1);
  assign sum  = {1'b0, qbase} + (QW + 1)'(inc);
  assign new_quota = sum[QW] ? '1 : sum[QW-1:0];
  assign prod = 32'(split) * 32'(mss_q);

  logic do_update;

  assign do_update = cmd_i.commit && op_q == bqps_pkg::OP_NEW && hit;
  assign ram_we    = do_update;
  assign ram_waddr = ch;
  assign ram_wdata = new_quota;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit && op_q == bqps_pkg::OP_NEW && clr_all) begin
      valid_d = valid_q & ~elig_vec;
    end
    if (do_update) begin
      valid_d[ch] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result register.
  logic                         found_q;
  logic [bqps_pkg::SUB_W-1:0]   sub_q;
  logic [bqps_pkg::LIMIT_W-1:0] limit_q;
  logic                         clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q <= hit;
      sub_q   <= hit ? bqps_pkg::SUB_W'(ch) : '0;
      limit_q <= (hit && op_q == bqps_pkg::OP_NEW) ? prod : '0;
      clr_q   <= hit && clr_out;
    end
  end

  assign out_found_o      = found_q;
  assign out_subpath_o    = sub_q;
  assign out_send_limit_o = limit_q;
  assign out_clear_sent_o = clr_q;

  assign status_o.scan_end = cnt_q == CW'(NUM_PATHS);
  assign status_o.div_done = div_done;

endmodule

[hw/rtl/bqps_ctrl.sv]
// Controller state machine of the scheduler: input handshake, scan sequencing,
// commit timing and the output valid flag. Depends on bqps_pkg.
`timescale 1ns / 1ps

module bqps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bqps_pkg::ctrl_cmd_t  cmd_o,
  input  bqps_pkg::dp_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = state_q == ST_IDLE;
  assign cmd_o.load   = state_q == ST_IDLE && in_valid_i;
  assign cmd_o.step   = state_q == ST_SCAN;
  assign cmd_o.commit = state_q == ST_FINISH && status_i.div_done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_end) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/burst_quota_path_scheduler.sv]
// Burst quota path scheduler: picks a subpath for each outgoing segment.
// The input beat on the s_axis group carries one segment request; the
// m_axis group returns one decision beat per request, in order.
// Configuration writes use cfg_valid_i/cfg_index_i/cfg_data_i; index 0 is
// the burst size in segments (reset 10000), index 1 selects window-checked
// eligibility (reset 1). Writes are always taken and are meant for idle time.
// A request scans the quota RAM, one read a cycle, while the serial ceiling
// divider runs; the commit waits until both the scan and the divider are done.
// The next input beat is taken in the cycle after commit, so requests do not
// overlap: a new one is taken only once the previous one has committed.
// The result sits in an output register; a stalled receiver does not block
// the next request, which waits before its commit only if the previous
// result is still held. Reset clears all quotas through per-entry valid bits,
// so the block is ready as soon as reset is released.
// Depends on bqps_pkg, bqps_ctrl, bqps_datapath, bqps_div and bqps_ram.
`timescale 1ns / 1ps

module burst_quota_path_scheduler #(
  parameter int unsigned NUM_PATHS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: seg_len[15:0], mss_now[31:16], avail_window[39:32],
  // avail_plain[47:40], sent_mask[55:48], is_data_fin[56], rcv_shut[57],
  // fin_path[60:58], zero fill [63:61].
  input  logic [63:0] s_axis_tdata,
  // Fields from bit 0: op.
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: subpath[2:0], send_limit[34:3], clear_sent[35],
  // zero fill [39:36].
  output logic [39:0] m_axis_tdata,
  // Fields from bit 0: found.
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [bqps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bqps_pkg::BURST_W-1:0]   cfg_data_i
);

  bqps_pkg::ctrl_cmd_t  cmd;
  bqps_pkg::dp_status_t status;

  logic                         found;
  logic [bqps_pkg::SUB_W-1:0]   subpath;
  logic [bqps_pkg::LIMIT_W-1:0] send_limit;
  logic                         clear_sent;

  assign cfg_ready_o = 1'b1;

  bqps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  bqps_datapath #(
    .NUM_PATHS (NUM_PATHS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_op_i           (s_axis_tuser),
    .in_seg_len_i      (s_axis_tdata[15:0]),
    .in_mss_now_i      (s_axis_tdata[31:16]),
    .in_avail_window_i (s_axis_tdata[39:32]),
    .in_avail_plain_i  (s_axis_tdata[47:40]),
    .in_sent_mask_i    (s_axis_tdata[55:48]),
    .in_is_data_fin_i  (s_axis_tdata[56]),
    .in_rcv_shut_i     (s_axis_tdata[57]),
    .in_fin_path_i     (s_axis_tdata[60:58]),
    .out_found_o       (found),
    .out_subpath_o     (subpath),
    .out_send_limit_o  (send_limit),
    .out_clear_sent_o  (clear_sent)
  );

  assign m_axis_tdata = {4'b0, clear_sent, send_limit, subpath};
  assign m_axis_tuser = found;

endmodule

[verif/tb_burst_quota_path_scheduler.sv]
`timescale 1ns / 1ps
// Self-checking bench for burst_quota_path_scheduler: directed and random segment requests
// under several register settings, each decision beat checked against an in-bench predictor.
// Depends on bqps_pkg and the scheduler RTL only.

module tb_burst_quota_path_scheduler;

  localparam int unsigned LEN_W     = bqps_pkg::LEN_W;
  localparam int unsigned MASK_W    = bqps_pkg::MASK_W;
  localparam int unsigned SUB_W     = bqps_pkg::SUB_W;
  localparam int unsigned LIMIT_W   = bqps_pkg::LIMIT_W;
  localparam int unsigned QUOTA_W   = bqps_pkg::QUOTA_W;
  localparam int unsigned BURST_W   = bqps_pkg::BURST_W;
  localparam int unsigned CFG_IDX_W = bqps_pkg::CFG_IDX_W;

  localparam int unsigned NUM_PATHS = 8;
  localparam int unsigned QUOTA_SAT = (1 << QUOTA_W) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic              op;
    logic [LEN_W-1:0]  seg_len;
    logic [LEN_W-1:0]  mss;
    logic [MASK_W-1:0] avail_win;
    logic [MASK_W-1:0] avail_any;
    logic [MASK_W-1:0] sent;
    logic              fin_flag;
    logic              rcv_shut;
    logic [SUB_W-1:0]  fin_path;
  } seg_req_t;

  typedef struct packed {
    logic               found;
    logic [SUB_W-1:0]   sub;
    logic [LIMIT_W-1:0] limit;
    logic               clr;
  } decision_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BURST_W-1:0]   cfg_data_i = '0;

  seg_req_t  seg_queue[$];
  decision_t decision_q[$];
  seg_req_t  cur_seg;
  decision_t want;

  logic [QUOTA_W-1:0] path_quota[NUM_PATHS];
  logic [BURST_W-1:0] burst_cfg;
  logic               window_cfg;
  logic [MASK_W-1:0]  steady_mask;

  logic in_fire = 1'b0;
  int   tx_gap = 0, tx_calm = 0, rx_hold = 0, rx_calm = 0;
  int   idle_cycles = 0;
  int   err_count = 0;
  int   n_req = 0, n_reinject = 0, n_checked = 0, n_cfg = 0;
  int   n_round_clears = 0, n_not_found = 0, n_clear_sent = 0;

  burst_quota_path_scheduler #(
    .NUM_PATHS(NUM_PATHS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic decision_t decide_path(input seg_req_t r);
    decision_t         d;
    logic [MASK_W-1:0] elig;
    int                chosen, best, backup, seen, full;
    bit                done;
    logic [31:0]       split, m, inc, q;
    d = '0;
    if (r.op == bqps_pkg::OP_REINJECT) begin
      n_reinject++;
      if (r.rcv_shut && r.fin_flag && r.avail_win[r.fin_path]) begin
        d.found = 1'b1;
        d.sub = r.fin_path;
      end else begin
        best = -1;
        backup = -1;
        for (int i = 0; i < NUM_PATHS; i++) begin
          if (r.avail_win[i]) begin
            if (r.sent[i]) backup = i;
            else best = i;
          end
        end
        if (best >= 0) begin
          d.found = 1'b1;
          d.sub = SUB_W'(best);
        end else if (backup >= 0) begin
          d.found = 1'b1;
          d.sub = SUB_W'(backup);
          d.clr = 1'b1;
        end
      end
    end else begin
      elig = window_cfg ? r.avail_win : r.avail_any;
      chosen = -1;
      split = 32'(burst_cfg);
      for (int pass = 0; pass < 2; pass++) begin
        seen = 0;
        full = 0;
        done = 1'b0;
        chosen = -1;
        split = 32'(burst_cfg);
        for (int i = 0; i < NUM_PATHS && !done; i++) begin
          if (elig[i]) begin
            seen++;
            if (path_quota[i] != 0 && path_quota[i] < burst_cfg) begin
              split = 32'(burst_cfg) - 32'(path_quota[i]);
              chosen = i;
              done = 1'b1;
            end else begin
              if (path_quota[i] == 0) begin
                split = 32'(burst_cfg);
                chosen = i;
              end
              if (path_quota[i] >= burst_cfg) full++;
            end
          end
        end
        if (done || seen == 0 || seen != full || pass == 1) break;
        for (int i = 0; i < NUM_PATHS; i++) begin
          if (elig[i]) path_quota[i] = '0;
        end
        n_round_clears++;
      end
      if (chosen >= 0 && r.avail_win[chosen]) begin
        m = (r.mss == 0) ? 32'd1 : 32'(r.mss);
        inc = (32'(r.seg_len) > m) ? (32'(r.seg_len) + m - 1) / m : 32'd1;
        q = 32'(path_quota[chosen]) + inc;
        d.found = 1'b1;
        d.sub = SUB_W'(chosen);
        d.limit = split * 32'(r.mss);
        path_quota[chosen] = (q > QUOTA_SAT) ? QUOTA_W'(QUOTA_SAT) : q[QUOTA_W-1:0];
      end
    end
    if (!d.found) n_not_found++;
    if (d.clr) n_clear_sent++;
    return d;
  endfunction

  function automatic seg_req_t mk_seg(input logic op, input int len, input int mss,
                                      input int aw, input int ap, input int sent,
                                      input logic dfin, input logic shut, input int fpath);
    seg_req_t r;
    r.op = op;
    r.seg_len = LEN_W'(len);
    r.mss = LEN_W'(mss);
    r.avail_win = MASK_W'(aw);
    r.avail_any = MASK_W'(ap);
    r.sent = MASK_W'(sent);
    r.fin_flag = dfin;
    r.rcv_shut = shut;
    r.fin_path = SUB_W'(fpath);
    return r;
  endfunction

  function automatic seg_req_t random_seg();
    seg_req_t r;
    int       mss, len, pick;
    r.op = ($urandom_range(0, 3) == 0) ? bqps_pkg::OP_REINJECT : bqps_pkg::OP_NEW;
    pick = $urandom_range(0, 9);
    if (pick < 4) mss = $urandom_range(1, 4);
    else if (pick < 6) mss = 1460;
    else if (pick < 7) mss = 65535;
    else mss = $urandom_range(0, 65535);
    r.mss = LEN_W'(mss);
    pick = $urandom_range(0, 9);
    if (pick < 5) len = $urandom_range(0, mss);
    else if (pick < 8) len = $urandom_range(0, 4 * mss);
    else len = $urandom_range(0, 65535);
    r.seg_len = (len > 65535) ? '1 : LEN_W'(len);
    pick = $urandom_range(0, 9);
    if (pick < 4) r.avail_win = steady_mask;
    else if (pick == 4) r.avail_win = '1;
    else if (pick == 5) r.avail_win = '0;
    else r.avail_win = MASK_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) r.avail_any = r.avail_win;
    else if (pick < 8) r.avail_any = MASK_W'($urandom);
    else r.avail_any = r.avail_win | MASK_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 3) r.sent = r.avail_win;
    else if (pick < 5) r.sent = '0;
    else r.sent = MASK_W'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      r.fin_flag = 1'b1;
      r.rcv_shut = 1'b1;
    end else begin
      r.fin_flag = 1'($urandom);
      r.rcv_shut = 1'($urandom);
    end
    r.fin_path = SUB_W'($urandom);
    return r;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: decision mismatch on %s: got 0x%0h, predicted 0x%0h",
               $time, field, got, exp_val);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BURST_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bqps_pkg::CFG_BURST_SEGMENTS) burst_cfg = val;
    else window_cfg = val[0];
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [BURST_W-1:0] burst, input logic win);
    cfg_write(bqps_pkg::CFG_BURST_SEGMENTS, burst);
    cfg_write(bqps_pkg::CFG_WINDOW_LIMITED, BURST_W'(win));
  endtask

  task automatic push_random(input int count);
    steady_mask = MASK_W'($urandom_range(1, 255));
    repeat (count) seg_queue.push_back(random_seg());
  endtask

  task automatic wait_idle();
    while (seg_queue.size() != 0 || s_axis_tvalid || decision_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: a new beat is presented only after the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (seg_queue.size() != 0) begin
        cur_seg = seg_queue.pop_front();
        s_axis_tdata <= {3'b000, cur_seg.fin_path, cur_seg.rcv_shut, cur_seg.fin_flag,
                         cur_seg.sent, cur_seg.avail_any, cur_seg.avail_win,
                         cur_seg.mss, cur_seg.seg_len};
        s_axis_tuser <= cur_seg.op;
        s_axis_tvalid <= 1'b1;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(10, 40);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        rx_hold = pick_gap();
        if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decision_q.push_back(decide_path(cur_seg));
      n_req++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decision_q.size() == 0) begin
        report_mismatch("unrequested beat", 32'(m_axis_tuser), 32'd0);
      end else begin
        want = decision_q.pop_front();
        n_checked++;
        if (m_axis_tuser !== want.found)
          report_mismatch("found", 32'(m_axis_tuser), 32'(want.found));
        if (m_axis_tdata[2:0] !== want.sub)
          report_mismatch("subpath", 32'(m_axis_tdata[2:0]), 32'(want.sub));
        if (m_axis_tdata[34:3] !== want.limit)
          report_mismatch("send_limit", m_axis_tdata[34:3], want.limit);
        if (m_axis_tdata[35] !== want.clr)
          report_mismatch("clear_sent", 32'(m_axis_tdata[35]), 32'(want.clr));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_PATHS; i++) path_quota[i] = '0;
    burst_cfg = bqps_pkg::BURST_RESET;
    window_cfg = 1'b1;
    steady_mask = 8'h0F;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: quotas start at zero.
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 0, 1, 'hFF, 'hFF, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 1460, 1460, 'hFF, 'hFF, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 65535, 1, 'h01, 'h00, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 65535, 65535, 'h01, 'h00, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 100, 0, 'h0F, 'h0F, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 500, 1000, 'h00, 'hFF, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 3000, 1000, 'h40, 'h40, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 0, 65535, 'h80, 'h00, 'hFF, 1, 1, 7));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 65535, 65535, 'hFF, 'hFF, 'hFF, 1, 1, 7));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 1000, 1000, 'h08, 'h08, 'h08, 1, 1, 3));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 1000, 1000, 'h0F, 'h0F, 'h02, 1, 1, 5));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 1000, 1000, 'h14, 'h00, 'h00, 1, 0, 2));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 1000, 1000, 'h24, 'h24, 'h24, 0, 1, 2));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 1000, 1000, 'h00, 'hFF, 'h00, 1, 1, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 65535, 65535, 'hFF, 'hFF, 'hFF,
                               1, 1, 7));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_REINJECT, 0, 0, 'h81, 'h00, 'h01, 0, 0, 0));
    wait_idle();

    set_config(16'd1, 1'b1);
    push_random(250);
    wait_idle();

    set_config(16'd3, 1'b0);
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 10, 10, 'h7F, 'h80, 0, 0, 0, 0));
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 10, 10, 'hFF, 'h00, 0, 0, 0, 0));
    push_random(250);
    wait_idle();

    set_config(16'hFFFF, 1'b1);
    push_random(200);
    wait_idle();

    set_config(16'd2, 1'b0);
    push_random(250);
    wait_idle();

    // A zero burst leaves every eligible path full even after the round clear.
    set_config(16'd0, 1'b1);
    seg_queue.push_back(mk_seg(bqps_pkg::OP_NEW, 1460, 1460, 'hFF, 'hFF, 0, 0, 0, 0));
    push_random(40);
    wait_idle();

    set_config(16'd7, 1'b1);
    push_random(300);
    wait_idle();

    set_config(16'd1000, 1'b0);
    push_random(340);
    wait_idle();

    $display("Checked %0d decision beats for %0d requests (%0d reinjected), %0d register writes.",
             n_checked, n_req, n_reinject, n_cfg);
    $display("Saw %0d full-round quota clears, %0d requests with no subpath, %0d clear_sent.",
             n_round_clears, n_not_found, n_clear_sent);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
